>>> sv/cts_pkg.sv
// Package for the commit timestamp sequencer: request and status codes,
// sequencer state type and default sizes. No dependencies.
package cts_pkg;

    // Width of the timestamp fields at the ports.
    localparam int PORT_TS_W = 64;

    // Default sizes handed to the top level.
    localparam int DEF_WINDOW  = 64;
    localparam int DEF_TS_BITS = 64;

    typedef enum logic [1:0] {
        REQ_ALLOCATE = 2'd0,
        REQ_COMPLETE = 2'd1,
        REQ_ADVANCE  = 2'd2,
        REQ_READ     = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_STALE  = 2'd1,
        STATUS_BEYOND = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_COMPLETE,
        ST_ADV_ALLOC,
        ST_ADV_MARK,
        ST_SLIDE,
        ST_DRAIN,
        ST_FINISH
    } seq_state_t;

endpackage

>>> sv/commit_timestamp_sequencer.sv
// Commit timestamp sequencer: hands out timestamps and tracks out-of-order
// completions behind an in-order visible watermark. Depends on cts_pkg.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-----------------------------------------
//   input   | in_valid / in_ready  | req_type[1:0], ts_value[63:0]
//   output  | out_valid / out_ready| result_ts[63:0], visible_ts[63:0],
//           |                      | status[1:0]
//
// Sequencing: one transaction is handled at a time by a small sequencer around a
// single TS_BITS-wide adder. From acceptance to the output register: a read
// goes straight to ST_FINISH; an allocate passes ST_ALLOC; a complete passes
// ST_COMPLETE, and a next-in-line one then drains in ST_DRAIN; an advance
// passes ST_ADV_ALLOC and ST_ADV_MARK, and one that raises the watermark then
// slides the window in ST_SLIDE (fewer than WINDOW positions, else it clears
// it) and drains in ST_DRAIN. The window shifts one bit per cycle.
// Reset: asynchronous, active low; counters, watermark and the done window
// are flip-flops cleared at once, so no clearing pass follows reset.
// Stalls: a new transaction is accepted while a finished result still waits in
// the output register; the sequencer holds only when its next result is ready
// and the output register is still occupied.
module commit_timestamp_sequencer
    import cts_pkg::*;
#(
    parameter int WINDOW  = DEF_WINDOW,
    parameter int TS_BITS = DEF_TS_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           req_type,
    input  logic [PORT_TS_W-1:0] ts_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PORT_TS_W-1:0] result_ts,
    output logic [PORT_TS_W-1:0] visible_ts,
    output logic [1:0]           status
);

    localparam int IDX_W = $clog2(WINDOW);

    // Architectural state.
    logic [TS_BITS-1:0] alloc_reg, alloc_next;
    logic [TS_BITS-1:0] mark_reg, mark_next;
    logic [WINDOW-1:0]  win_reg, win_next;

    // Sequencer and transaction registers.
    seq_state_t         state_reg, state_next;
    req_t               req_reg, req_next;
    logic [TS_BITS-1:0] ts_reg, ts_next;
    status_t            status_reg, status_next;
    logic [IDX_W-1:0]   slide_reg, slide_next;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    logic [TS_BITS-1:0]   result_out_reg, result_out_next;
    logic [TS_BITS-1:0]   visible_out_reg, visible_out_next;
    status_t              status_out_reg, status_out_next;

    // Shared adder: a + b + 1, or a - b when sub is set.
    logic [TS_BITS-1:0] unit_a, unit_b;
    logic               unit_sub;
    logic [TS_BITS:0]   unit_full;
    logic [TS_BITS-1:0] unit_sum;
    logic               unit_cout;
    logic               unit_gt;

    logic               accept;
    logic               out_free;
    logic               mark_max;
    logic               drain_go;
    logic [IDX_W-1:0]   set_idx;

    always_comb
    begin
        unit_a   = '0;
        unit_b   = '0;
        unit_sub = 1'b0;
        unique case (state_reg)
            ST_ALLOC:
            begin
                unit_a = alloc_reg;
            end
            ST_COMPLETE, ST_ADV_MARK:
            begin
                unit_a   = ts_reg;
                unit_b   = mark_reg;
                unit_sub = 1'b1;
            end
            ST_ADV_ALLOC:
            begin
                unit_a   = ts_reg;
                unit_b   = alloc_reg;
                unit_sub = 1'b1;
            end
            ST_DRAIN:
            begin
                unit_a = mark_reg;
            end
            default:
            begin
                unit_a = '0;
            end
        endcase
    end

    assign unit_full = {1'b0, unit_a} + {1'b0, (unit_sub ? ~unit_b : unit_b)}
                       + (TS_BITS + 1)'(1);
    assign unit_sum  = unit_full[TS_BITS-1:0];
    assign unit_cout = unit_full[TS_BITS];
    // In subtract mode: a strictly greater than b.
    assign unit_gt   = unit_cout && (unit_sum != '0);

    assign mark_max = (mark_reg == {TS_BITS{1'b1}});
    assign drain_go = win_reg[0] && !mark_max;
    // Window position of a completion: its distance above the watermark less one.
    assign set_idx  = unit_sum[IDX_W-1:0] - IDX_W'(1);

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_t'(req_type))
                        REQ_ALLOCATE: state_next = ST_ALLOC;
                        REQ_COMPLETE: state_next = ST_COMPLETE;
                        REQ_ADVANCE:  state_next = ST_ADV_ALLOC;
                        REQ_READ:     state_next = ST_FINISH;
                    endcase
                end
            end
            ST_ALLOC:
            begin
                state_next = ST_FINISH;
            end
            ST_COMPLETE:
            begin
                if (unit_gt && !mark_max && unit_sum == TS_BITS'(1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_ADV_ALLOC:
            begin
                state_next = ST_ADV_MARK;
            end
            ST_ADV_MARK:
            begin
                priority if (!unit_gt)
                begin
                    state_next = ST_FINISH;
                end
                else if (unit_sum >= TS_BITS'(WINDOW))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    state_next = ST_SLIDE;
                end
            end
            ST_SLIDE:
            begin
                if (slide_reg == IDX_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!drain_go)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output logic.
    always_comb
    begin
        alloc_next       = alloc_reg;
        mark_next        = mark_reg;
        win_next         = win_reg;
        req_next         = req_reg;
        ts_next          = ts_reg;
        status_next      = status_reg;
        slide_next       = slide_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        result_out_next  = result_out_reg;
        visible_out_next = visible_out_reg;
        status_out_next  = status_out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next    = req_t'(req_type);
                    ts_next     = ts_value[TS_BITS-1:0];
                    status_next = STATUS_OK;
                end
            end
            ST_ALLOC:
            begin
                alloc_next = unit_sum;
            end
            ST_COMPLETE:
            begin
                priority if (!unit_gt || mark_max)
                begin
                    status_next = STATUS_STALE;
                end
                else if (unit_sum == TS_BITS'(1))
                begin
                    mark_next = ts_reg;
                    win_next  = win_reg >> 1;
                end
                else if (unit_sum <= TS_BITS'(WINDOW))
                begin
                    win_next = win_reg | (WINDOW'(1) << set_idx);
                end
                else
                begin
                    status_next = STATUS_BEYOND;
                end
            end
            ST_ADV_ALLOC:
            begin
                if (unit_gt)
                begin
                    alloc_next = ts_reg;
                end
            end
            ST_ADV_MARK:
            begin
                if (unit_gt)
                begin
                    mark_next = ts_reg;
                    if (unit_sum >= TS_BITS'(WINDOW))
                    begin
                        win_next = '0;
                    end
                    else
                    begin
                        slide_next = unit_sum[IDX_W-1:0];
                    end
                end
            end
            ST_SLIDE:
            begin
                win_next   = win_reg >> 1;
                slide_next = slide_reg - IDX_W'(1);
            end
            ST_DRAIN:
            begin
                if (drain_go)
                begin
                    mark_next = unit_sum;
                    win_next  = win_reg >> 1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    result_out_next  = (req_reg == REQ_ALLOCATE) ? alloc_reg : mark_reg;
                    visible_out_next = mark_reg;
                    status_out_next  = status_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !out_ready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            alloc_reg     <= '0;
            mark_reg      <= '0;
            win_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            alloc_reg     <= alloc_next;
            mark_reg      <= mark_next;
            win_reg       <= win_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        ts_reg          <= ts_next;
        status_reg      <= status_next;
        slide_reg       <= slide_next;
        result_out_reg  <= result_out_next;
        visible_out_reg <= visible_out_next;
        status_out_reg  <= status_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign result_ts  = PORT_TS_W'(result_out_reg);
    assign visible_ts = PORT_TS_W'(visible_out_reg);
    assign status     = status_out_reg;

    // The watermark only ever moves forward.
    a_mark_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (mark_reg >= $past(mark_reg)))
        else $error("visible watermark moved backward");

    // Whenever a result is formed, the number just above the watermark is
    // not left marked done unless the watermark is saturated.
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> (!win_reg[0] || mark_max))
        else $error("done window not drained before result");

    // Only completions report a non-ok status.
    a_status_src: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && status_reg != STATUS_OK)
            |-> (req_reg == REQ_COMPLETE))
        else $error("non-ok status on a request that is not a completion");

    // An allocation raises the counter by exactly one.
    a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALLOC) |=> (alloc_reg == TS_BITS'($past(alloc_reg) + 1'b1)))
        else $error("allocation counter did not step by one");

endmodule
